FILE: rtl/core/multi_waveform_phase_oscillator_defines.svh
// Assertion macros shared by the oscillator RTL.
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_DEFINES_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MWPO_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("mwpo assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MWPO_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("mwpo assertion failed");

`endif

FILE: rtl/core/mwpo_pkg.sv
// Types, constants and the sine table builder for the waveform oscillator.
package mwpo_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_TABLE_WIDTH = 18;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_PROD_W      = 30 + $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_SHIFT       = 28 - SINE_TABLE_WIDTH;

    localparam int PHASE_W  = 32;
    localparam int CFG_W    = 30;
    localparam int SAMPLE_W = 32;

    localparam logic signed [PHASE_W-1:0] ONE_CYCLE   = 32'sh4000_0000;
    localparam logic signed [PHASE_W-1:0] TWO_CYCLES  = 32'sh8000_0000;
    localparam logic signed [PHASE_W-1:0] HALF_CYCLE  = 32'sh2000_0000;
    localparam logic signed [PHASE_W:0]   QUARTER_X   = 33'sh0_1000_0000;
    localparam logic signed [PHASE_W:0]   THREE_QTR_X = 33'sh0_3000_0000;

    localparam logic signed [SAMPLE_W-1:0] SQUARE_HIGH = 32'sh0800_0000;
    localparam logic signed [SAMPLE_W-1:0] SQUARE_LOW  = -32'sh0800_0000;

    localparam logic [CFG_W-1:0] INC_RESET  = 30'd15665;
    localparam logic [31:0]      LFSR_TAPS  = 32'h8020_0003;
    localparam logic [31:0]      LFSR_RESET = 32'h0000_0001;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SAWTOOTH = 3'd2,
        WAVE_SQUARE   = 3'd3,
        WAVE_PHASOR   = 3'd4,
        WAVE_NOISE    = 3'd5
    } wave_t;

    typedef enum logic [0:0] {
        CFG_PHASE_INCREMENT = 1'b0,
        CFG_START_PHASE     = 1'b1
    } cfg_index_t;

    // Result of the core for one item; sine items carry their value in the ROM word.
    typedef struct packed {
        logic                       is_sine;
        logic signed [SAMPLE_W-1:0] sample;
    } stage_t;

    typedef logic signed [SINE_TABLE_WIDTH-1:0] sine_word_t;
    typedef sine_word_t sine_table_t [SINE_TABLE_DEPTH];

    typedef longint unsigned taylor_div_t [8];
    localparam taylor_div_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72,
                                           64'd110, 64'd156, 64'd210, 64'd272};

    // Quadrant fold plus Taylor series in Q30, evaluated at elaboration.
    function automatic sine_table_t build_sine_table();
        sine_table_t       tbl;
        longint unsigned   f;
        longint unsigned   quad;
        longint unsigned   r;
        longint unsigned   th;
        longint unsigned   term;
        longint            sum;
        longint            mag;
        longint            lim;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            f    = (longint'(k) << 30) / SINE_TABLE_DEPTH;
            quad = (f >> 28) & 64'd3;
            r    = f & 64'h0FFF_FFFF;
            if (quad[0])
            begin
                r = 64'h1000_0000 - r;
            end
            th   = (r * HALF_PI_Q30) >> 28;
            term = th;
            sum  = longint'(th);
            for (int n = 0; n < 8; n++) begin
                term = (term * th) >> 30;
                term = (term * th) >> 30;
                term = term / TAYLOR_DIV[n];
                if (n % 2 == 0)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > 64'sd1073741824)
            begin
                sum = 64'sd1073741824;
            end
            mag = (sum + (64'sd1 << (30 - SINE_TABLE_WIDTH))) >>> (31 - SINE_TABLE_WIDTH);
            lim = (64'sd1 <<< (SINE_TABLE_WIDTH - 1)) - 1;
            if (mag > lim)
            begin
                mag = lim;
            end
            tbl[k] = quad[1] ? SINE_TABLE_WIDTH'(-mag) : SINE_TABLE_WIDTH'(mag);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

FILE: rtl/core/mwpo_sine_rom.sv
// Sine ROM with registered read data.
module mwpo_sine_rom (
    input  logic                                 clk,
    input  logic                                 rd_en,
    input  logic [mwpo_pkg::SINE_IDX_W-1:0]      rd_addr,
    output mwpo_pkg::sine_word_t                 rd_data
);
    import mwpo_pkg::*;

    sine_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= SINE_TABLE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/mwpo_core.sv
// Phase accumulator, square level, noise LFSR and per-waveform sample logic.
`include "multi_waveform_phase_oscillator_defines.svh"

module mwpo_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  mwpo_pkg::cfg_index_t              cfg_index,
    input  logic [mwpo_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              accept,
    input  logic [2:0]                        waveform,
    output logic [mwpo_pkg::SINE_IDX_W-1:0]   sine_addr,
    output mwpo_pkg::stage_t                  stage_next
);
    import mwpo_pkg::*;

    logic signed [PHASE_W-1:0] phase_reg, phase_next;
    logic [CFG_W-1:0]          inc_reg, inc_next;
    logic                      square_level_reg, square_level_next;
    logic [31:0]               lfsr_reg, lfsr_next;

    logic                      at_wrap;
    logic signed [PHASE_W-1:0] wrap_amount;
    logic signed [PHASE_W-1:0] phase_adv;
    logic signed [PHASE_W:0]   tri_diff;
    logic [31:0]               lfsr_step;
    logic [SINE_PROD_W-1:0]    sine_prod;

    // Index of the pre-update phase, fraction only.
    assign sine_prod = SINE_PROD_W'(phase_reg[29:0]) * SINE_PROD_W'(SINE_TABLE_DEPTH);
    assign sine_addr = SINE_IDX_W'(sine_prod >> 30);

    assign at_wrap     = (phase_reg >= ONE_CYCLE);
    assign wrap_amount = (wave_t'(waveform) == WAVE_SAWTOOTH) ? TWO_CYCLES : ONE_CYCLE;
    assign phase_adv   = (at_wrap ? phase_reg - wrap_amount : phase_reg)
                         + signed'({2'b00, inc_reg});
    assign lfsr_step   = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'h0);

    always_comb
    begin
        phase_next         = phase_reg;
        inc_next           = inc_reg;
        square_level_next  = square_level_reg;
        lfsr_next          = lfsr_reg;
        stage_next.is_sine = 1'b0;
        stage_next.sample  = '0;
        tri_diff           = '0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_PHASE_INCREMENT: inc_next = cfg_data;
                CFG_START_PHASE:     phase_next = signed'({2'b00, cfg_data});
                default:             inc_next = inc_reg;
            endcase
        end
        else if (accept)
        begin
            case (wave_t'(waveform))
                WAVE_SINE:
                begin
                    stage_next.is_sine = 1'b1;
                    phase_next         = phase_adv;
                end
                WAVE_TRIANGLE:
                begin
                    phase_next = phase_adv;
                    if (phase_adv <= HALF_CYCLE)
                    begin
                        tri_diff = {phase_adv[PHASE_W-1], phase_adv} - QUARTER_X;
                    end
                    else
                    begin
                        tri_diff = THREE_QTR_X - {phase_adv[PHASE_W-1], phase_adv};
                    end
                    // arithmetic halving, rounds toward minus infinity
                    stage_next.sample = tri_diff[PHASE_W:1];
                end
                WAVE_SAWTOOTH, WAVE_PHASOR:
                begin
                    phase_next        = phase_adv;
                    stage_next.sample = phase_reg >>> 3;
                end
                WAVE_SQUARE:
                begin
                    phase_next = phase_adv;
                    if (phase_reg < HALF_CYCLE)
                    begin
                        square_level_next = 1'b0;
                    end
                    else if (phase_reg > HALF_CYCLE)
                    begin
                        square_level_next = 1'b1;
                    end
                    stage_next.sample = square_level_next ? SQUARE_HIGH : SQUARE_LOW;
                end
                WAVE_NOISE:
                begin
                    lfsr_next         = lfsr_step;
                    stage_next.sample = signed'({5'b00000, lfsr_step[31:5]});
                end
                default:
                begin
                    stage_next.sample = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            inc_reg          <= INC_RESET;
            square_level_reg <= 1'b0;
            lfsr_reg         <= LFSR_RESET;
        end
        else
        begin
            phase_reg        <= phase_next;
            inc_reg          <= inc_next;
            square_level_reg <= square_level_next;
            lfsr_reg         <= lfsr_next;
        end
    end

    // phase never leaves [-1.0, 2.0)
    `MWPO_ASSERT_NOW(a_phase_range, 1'b1, !(phase_reg[31] && !phase_reg[30]))
    `MWPO_ASSERT_NOW(a_lfsr_nonzero, 1'b1, lfsr_reg != 32'h0)
    `MWPO_ASSERT_NEXT(a_unknown_keeps_state,
        accept && !cfg_write && (waveform > WAVE_NOISE),
        $stable(phase_reg) && $stable(lfsr_reg) && $stable(square_level_reg))

endmodule

FILE: rtl/core/multi_waveform_phase_oscillator.sv
// Top level of the multi-waveform phase oscillator.
//   channel | direction | payload        | handshake
//   in      | input     | waveform [2:0] | in_valid / in_stall
//   out     | output    | sample [31:0]  | out_valid / out_stall
//   cfg     | input     | cfg_data [29:0]| cfg_write, cfg_index
// One item per cycle sustained while out_stall is low; a result moves from its
// input transfer, where the state update and sine ROM read happen, through the
// middle stage to the output register; out_valid rises as that register loads.
// Reset zeroes phase, square level, both valid flags; seeds LFSR, increment.
// A stalled output holds; the input keeps flowing while the middle stage is free.
`include "multi_waveform_phase_oscillator_defines.svh"

module multi_waveform_phase_oscillator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  mwpo_pkg::cfg_index_t          cfg_index,
    input  logic [mwpo_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    waveform,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [mwpo_pkg::SAMPLE_W-1:0] sample
);
    import mwpo_pkg::*;

    logic                       accept;
    logic                       out_take;
    logic                       s1_free;
    logic                       s1_valid_reg, s1_valid_next;
    stage_t                     s1_reg;
    stage_t                     stage_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] merged;
    logic [SINE_IDX_W-1:0]      sine_addr;
    sine_word_t                 sine_word;

    assign out_take = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || out_take;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    mwpo_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .waveform   (waveform),
        .sine_addr  (sine_addr),
        .stage_next (stage_next)
    );

    mwpo_sine_rom u_rom (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (sine_addr),
        .rd_data (sine_word)
    );

    assign merged = s1_reg.is_sine ? (SAMPLE_W'(sine_word) <<< SINE_SHIFT) : s1_reg.sample;

    assign s1_valid_next  = accept || (s1_valid_reg && !out_take);
    assign out_valid_next = out_take ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage_next;
        end
        if (out_take && s1_valid_reg)
        begin
            sample_reg <= merged;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    `MWPO_ASSERT_NEXT(a_s1_holds_when_blocked,
        s1_valid_reg && out_valid_reg && out_stall,
        s1_valid_reg && $stable(s1_reg))
    `MWPO_ASSERT_NEXT(a_out_drains,
        out_valid_reg && !out_stall && !s1_valid_reg,
        !out_valid_reg)
    `MWPO_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg)

endmodule
